### rtl/dmbp_pkg.sv
`timescale 1ns / 1ps

package dmbp_pkg;

    localparam int RATIO_FRAC_BITS = 16;

    localparam int RES_W    = 13;
    localparam int RATE_W   = 10;
    localparam int MM_W     = 12;
    localparam int ID_W     = 32;
    localparam int MARGIN_W = 16;
    localparam int PROD_W   = RES_W + MM_W;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    localparam logic [RES_W-1:0]    WANTED_WIDTH_RST  = RES_W'(768);
    localparam logic [RES_W-1:0]    WANTED_HEIGHT_RST = RES_W'(432);
    localparam logic [RATE_W-1:0]   WANTED_RATE_RST   = RATE_W'(60);
    localparam logic [RES_W-1:0]    WIDTH_CAP_RST     = RES_W'(1920);
    localparam logic [MARGIN_W-1:0] ASPECT_MARGIN_RST = MARGIN_W'(6554);

    typedef enum logic [2:0] {
        REG_WANTED_WIDTH  = 3'd0,
        REG_WANTED_HEIGHT = 3'd1,
        REG_WANTED_RATE   = 3'd2,
        REG_WIDTH_CAP     = 3'd3,
        REG_ASPECT_MARGIN = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic               connected;
        logic [RES_W-1:0]   mode_width;
        logic [RES_W-1:0]   mode_height;
        logic [RATE_W-1:0]  mode_rate;
        logic               preferred;
        logic [MM_W-1:0]    panel_width_mm;
        logic [MM_W-1:0]    panel_height_mm;
        logic [ID_W-1:0]    connector_ident;
        logic [ID_W-1:0]    encoder_ident;
        logic               last_mode;
    } mode_t;

    typedef struct packed {
        logic               found;
        logic [RES_W-1:0]   chosen_width;
        logic [RES_W-1:0]   chosen_height;
        logic [RATE_W-1:0]  chosen_rate;
        logic [ID_W-1:0]    chosen_connector;
        logic [ID_W-1:0]    chosen_encoder;
        logic [MM_W-1:0]    chosen_width_mm;
        logic [MM_W-1:0]    chosen_height_mm;
    } choice_t;

    typedef struct packed {
        logic [RES_W-1:0]    wanted_width;
        logic [RES_W-1:0]    wanted_height;
        logic [RATE_W-1:0]   wanted_rate;
        logic [RES_W-1:0]    width_cap;
        logic [MARGIN_W-1:0] aspect_margin;
    } cfg_t;

    typedef struct packed {
        logic [RES_W-1:0]  width;
        logic [RES_W-1:0]  height;
        logic [RATE_W-1:0] rate;
        logic              preferred;
        logic [MM_W-1:0]   width_mm;
        logic [MM_W-1:0]   height_mm;
        logic [ID_W-1:0]   connector;
        logic [ID_W-1:0]   encoder;
    } best_t;

    typedef struct packed {
        logic [RES_W-1:0] width;
        logic [RES_W-1:0] height;
        logic [MM_W-1:0]  width_mm;
        logic [MM_W-1:0]  height_mm;
    } ratio_operands_t;

    typedef enum logic [2:0] {
        R_IDLE,
        R_MUL_NUM,
        R_MUL_DEN,
        R_SETUP,
        R_DIV,
        R_DONE
    } ratio_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_BEST,
        S_NEW,
        S_FINISH
    } pick_state_t;

endpackage

### rtl/dmbp_if.sv
`timescale 1ns / 1ps

interface dmbp_mode_if;
    logic            valid;
    logic            ready;
    dmbp_pkg::mode_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dmbp_choice_if;
    logic              valid;
    logic              ready;
    dmbp_pkg::choice_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/dmbp_cfg_regs.sv
`timescale 1ns / 1ps

module dmbp_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmbp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dmbp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dmbp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output dmbp_pkg::cfg_t                      cfg
);

    dmbp_pkg::cfg_t         cfg_reg;
    dmbp_pkg::cfg_t         cfg_next;
    dmbp_pkg::reg_index_t   index;
    logic                   wr_en;

    assign index  = dmbp_pkg::reg_index_t'(paddr[dmbp_pkg::CFG_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                dmbp_pkg::REG_WANTED_WIDTH:
                    cfg_next.wanted_width = pwdata[dmbp_pkg::RES_W-1:0];
                dmbp_pkg::REG_WANTED_HEIGHT:
                    cfg_next.wanted_height = pwdata[dmbp_pkg::RES_W-1:0];
                dmbp_pkg::REG_WANTED_RATE:
                    cfg_next.wanted_rate = pwdata[dmbp_pkg::RATE_W-1:0];
                dmbp_pkg::REG_WIDTH_CAP:
                    cfg_next.width_cap = pwdata[dmbp_pkg::RES_W-1:0];
                dmbp_pkg::REG_ASPECT_MARGIN:
                    cfg_next.aspect_margin = pwdata[dmbp_pkg::MARGIN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            dmbp_pkg::REG_WANTED_WIDTH:
                prdata = dmbp_pkg::CFG_DATA_W'(cfg_reg.wanted_width);
            dmbp_pkg::REG_WANTED_HEIGHT:
                prdata = dmbp_pkg::CFG_DATA_W'(cfg_reg.wanted_height);
            dmbp_pkg::REG_WANTED_RATE:
                prdata = dmbp_pkg::CFG_DATA_W'(cfg_reg.wanted_rate);
            dmbp_pkg::REG_WIDTH_CAP:
                prdata = dmbp_pkg::CFG_DATA_W'(cfg_reg.width_cap);
            dmbp_pkg::REG_ASPECT_MARGIN:
                prdata = dmbp_pkg::CFG_DATA_W'(cfg_reg.aspect_margin);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wanted_width  <= dmbp_pkg::WANTED_WIDTH_RST;
            cfg_reg.wanted_height <= dmbp_pkg::WANTED_HEIGHT_RST;
            cfg_reg.wanted_rate   <= dmbp_pkg::WANTED_RATE_RST;
            cfg_reg.width_cap     <= dmbp_pkg::WIDTH_CAP_RST;
            cfg_reg.aspect_margin <= dmbp_pkg::ASPECT_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/dmbp_ratio_unit.sv
`timescale 1ns / 1ps

module dmbp_ratio_unit
#(
    parameter int RATIO_FRAC_BITS = dmbp_pkg::RATIO_FRAC_BITS,
    localparam int SCORE_W = 8 + RATIO_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  dmbp_pkg::ratio_operands_t   operands,
    output logic                        done,
    output logic [SCORE_W-1:0]          score
);

    localparam int PROD_W = dmbp_pkg::PROD_W;
    localparam int CNT_W  = $clog2(SCORE_W);

    dmbp_pkg::ratio_state_t state_reg, state_next;

    logic [PROD_W-1:0]  num_reg, num_next;
    logic [PROD_W-1:0]  den_reg, den_next;
    logic [PROD_W-1:0]  rem_reg, rem_next;
    logic [SCORE_W-1:0] bits_reg, bits_next;
    logic [SCORE_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [dmbp_pkg::RES_W-1:0] mul_a;
    logic [dmbp_pkg::MM_W-1:0]  mul_b;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-1:0]          hi;
    logic [PROD_W-1:0]          lo;
    logic                       saturate;
    logic [PROD_W:0]            shifted;
    logic                       fits;
    logic [PROD_W:0]            diff;

    // one multiplier: width * height_mm first, then height * width_mm
    assign mul_a = (state_reg == dmbp_pkg::R_MUL_NUM) ? operands.width : operands.height;
    assign mul_b = (state_reg == dmbp_pkg::R_MUL_NUM) ? operands.height_mm
                                                       : operands.width_mm;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign hi = (num_reg >= den_reg) ? num_reg : den_reg;
    assign lo = (num_reg >= den_reg) ? den_reg : num_reg;

    // quotient overflows Q8.F exactly when hi >= 256 * lo
    assign saturate = (lo == '0) || ({8'b0, hi} >= {lo, 8'b0});

    // restoring division, one quotient bit per cycle; den_reg holds the divisor
    assign shifted = {rem_reg, bits_reg[SCORE_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    assign done  = (state_reg == dmbp_pkg::R_DONE);
    assign score = quo_reg;

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            dmbp_pkg::R_IDLE:
            begin
                if (start)
                begin
                    state_next = dmbp_pkg::R_MUL_NUM;
                end
            end
            dmbp_pkg::R_MUL_NUM:
            begin
                num_next   = prod;
                state_next = dmbp_pkg::R_MUL_DEN;
            end
            dmbp_pkg::R_MUL_DEN:
            begin
                den_next   = prod;
                state_next = dmbp_pkg::R_SETUP;
            end
            dmbp_pkg::R_SETUP:
            begin
                if (saturate)
                begin
                    quo_next   = '1;
                    state_next = dmbp_pkg::R_DONE;
                end
                else
                begin
                    // hi >> 8 is already below the divisor
                    den_next   = lo;
                    rem_next   = PROD_W'(hi >> 8);
                    bits_next  = {hi[7:0], {RATIO_FRAC_BITS{1'b0}}};
                    cnt_next   = CNT_W'(SCORE_W - 1);
                    state_next = dmbp_pkg::R_DIV;
                end
            end
            dmbp_pkg::R_DIV:
            begin
                rem_next  = fits ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
                bits_next = {bits_reg[SCORE_W-2:0], 1'b0};
                quo_next  = {quo_reg[SCORE_W-2:0], fits};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = dmbp_pkg::R_DONE;
                end
            end
            dmbp_pkg::R_DONE:
            begin
                state_next = dmbp_pkg::R_IDLE;
            end
            default:
            begin
                state_next = dmbp_pkg::R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmbp_pkg::R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
    end

endmodule

### rtl/display_mode_best_picker.sv
`timescale 1ns / 1ps

// Keeps the best connected display mode out of a list offered one candidate per
// transfer and hands out the choice (found = 0 and all fields zero if nothing
// connected was seen) in one transfer after the candidate marked last_mode,
// then starts over. One candidate is taken at a time. A disconnected candidate
// or one settled by rate, size, width cap, preferred flag or plain size is
// decided in S_EVAL. When the aspect test is needed, one shared multiply/divide
// unit scores the current best and then the candidate, each pass with its two
// multiplies, a setup step and a restoring divide (setup ends it on a zero or
// overflowing ratio). The choice waits in an output register; a last
// candidate that finds it still full holds there until it is taken. Registers
// sit at byte address 4*i: wanted_width, wanted_height, wanted_rate, width_cap,
// aspect_margin (Q0.16).
module display_mode_best_picker
#(
    parameter int RATIO_FRAC_BITS = dmbp_pkg::RATIO_FRAC_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    dmbp_mode_if.sink                       mode_in,
    dmbp_choice_if.source                   choice_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmbp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dmbp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dmbp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int SCORE_W = 8 + RATIO_FRAC_BITS;
    localparam int MARGIN_W = dmbp_pkg::MARGIN_W;

    dmbp_pkg::cfg_t cfg;

    dmbp_pkg::pick_state_t state_reg, state_next;
    dmbp_pkg::mode_t       cand_reg, cand_next;
    logic                  have_best_reg, have_best_next;
    dmbp_pkg::best_t       best_reg, best_next;
    logic [SCORE_W-1:0]    best_score_reg, best_score_next;
    logic                  out_valid_reg, out_valid_next;
    dmbp_pkg::choice_t     out_data_reg, out_data_next;

    logic                       ratio_start;
    logic                       ratio_done;
    logic [SCORE_W-1:0]         ratio_score;
    dmbp_pkg::ratio_operands_t  ratio_ops;

    logic best_rate_ok, new_rate_ok;
    logic best_small, new_small;
    logic best_capped, new_capped;
    logic rank_decided, rank_win;
    logic size_win;
    logic aspect_on;
    logic aspect_win, aspect_lose;
    logic take_new;
    logic load_out;
    logic out_free;

    logic [MARGIN_W+RATIO_FRAC_BITS-1:0] margin_full;
    logic [RATIO_FRAC_BITS-1:0]          margin;
    logic [SCORE_W:0]                    best_plus_m;
    logic [SCORE_W:0]                    new_plus_m;

    dmbp_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        if (state_reg == dmbp_pkg::S_NEW)
        begin
            ratio_ops.width     = cand_reg.mode_width;
            ratio_ops.height    = cand_reg.mode_height;
            ratio_ops.width_mm  = cand_reg.panel_width_mm;
            ratio_ops.height_mm = cand_reg.panel_height_mm;
        end
        else
        begin
            ratio_ops.width     = best_reg.width;
            ratio_ops.height    = best_reg.height;
            ratio_ops.width_mm  = best_reg.width_mm;
            ratio_ops.height_mm = best_reg.height_mm;
        end
    end

    dmbp_ratio_unit #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_ratio_unit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ratio_start),
        .operands (ratio_ops),
        .done     (ratio_done),
        .score    (ratio_score)
    );

    // ranking rules ahead of the aspect test
    assign best_rate_ok = (best_reg.rate == cfg.wanted_rate);
    assign new_rate_ok  = (cand_reg.mode_rate == cfg.wanted_rate);
    assign best_small   = (best_reg.width < cfg.wanted_width)
                       || (best_reg.height < cfg.wanted_height);
    assign new_small    = (cand_reg.mode_width < cfg.wanted_width)
                       || (cand_reg.mode_height < cfg.wanted_height);
    assign best_capped  = (best_reg.width <= cfg.width_cap);
    assign new_capped   = (cand_reg.mode_width <= cfg.width_cap);

    always_comb
    begin
        rank_decided = 1'b1;
        rank_win     = 1'b1;
        if (!have_best_reg)
        begin
            rank_win = 1'b1;
        end
        else if (best_rate_ok != new_rate_ok)
        begin
            rank_win = new_rate_ok;
        end
        else if (best_small != new_small)
        begin
            rank_win = best_small;
        end
        else if (best_capped != new_capped)
        begin
            rank_win = new_capped;
        end
        else if (best_reg.preferred != cand_reg.preferred)
        begin
            rank_win = cand_reg.preferred;
        end
        else
        begin
            rank_decided = 1'b0;
        end
    end

    assign size_win = (cand_reg.mode_width != best_reg.width)
                    ? (cand_reg.mode_width > best_reg.width)
                    : (cand_reg.mode_height > best_reg.height);

    assign aspect_on = ((best_reg.width != cand_reg.mode_width)
                     || (best_reg.height != cand_reg.mode_height))
                    && (best_reg.width_mm != '0) && (best_reg.height_mm != '0)
                    && (cand_reg.panel_width_mm != '0)
                    && (cand_reg.panel_height_mm != '0);

    // margin rescaled from Q0.16 to Q0.F, truncating
    assign margin_full = {cfg.aspect_margin, {RATIO_FRAC_BITS{1'b0}}};
    assign margin      = margin_full[MARGIN_W+RATIO_FRAC_BITS-1:MARGIN_W];
    assign best_plus_m = {1'b0, best_score_reg} + (SCORE_W+1)'(margin);
    assign new_plus_m  = {1'b0, ratio_score} + (SCORE_W+1)'(margin);
    assign aspect_win  = ({1'b0, best_score_reg} > new_plus_m);
    assign aspect_lose = ({1'b0, ratio_score} > best_plus_m);

    assign out_free = !out_valid_reg || choice_out.ready;

    always_comb
    begin
        state_next      = state_reg;
        cand_next       = cand_reg;
        best_score_next = best_score_reg;
        mode_in.ready   = 1'b0;
        ratio_start     = 1'b0;
        take_new        = 1'b0;
        load_out        = 1'b0;
        case (state_reg)
            dmbp_pkg::S_IDLE:
            begin
                mode_in.ready = 1'b1;
                if (mode_in.valid)
                begin
                    cand_next  = mode_in.data;
                    state_next = dmbp_pkg::S_EVAL;
                end
            end
            dmbp_pkg::S_EVAL:
            begin
                if (!cand_reg.connected)
                begin
                    state_next = dmbp_pkg::S_FINISH;
                end
                else if (rank_decided)
                begin
                    take_new   = rank_win;
                    state_next = dmbp_pkg::S_FINISH;
                end
                else if (!aspect_on)
                begin
                    take_new   = size_win;
                    state_next = dmbp_pkg::S_FINISH;
                end
                else
                begin
                    state_next = dmbp_pkg::S_BEST;
                end
            end
            dmbp_pkg::S_BEST:
            begin
                ratio_start = 1'b1;
                if (ratio_done)
                begin
                    best_score_next = ratio_score;
                    state_next      = dmbp_pkg::S_NEW;
                end
            end
            dmbp_pkg::S_NEW:
            begin
                ratio_start = 1'b1;
                if (ratio_done)
                begin
                    if (aspect_win)
                    begin
                        take_new = 1'b1;
                    end
                    else if (aspect_lose)
                    begin
                        take_new = 1'b0;
                    end
                    else
                    begin
                        take_new = size_win;
                    end
                    state_next = dmbp_pkg::S_FINISH;
                end
            end
            dmbp_pkg::S_FINISH:
            begin
                if (!cand_reg.last_mode)
                begin
                    state_next = dmbp_pkg::S_IDLE;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = dmbp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dmbp_pkg::S_IDLE;
            end
        endcase
    end

    // best is all zero whenever have_best is clear, so the result needs no masking
    always_comb
    begin
        have_best_next = have_best_reg;
        best_next      = best_reg;
        if (take_new)
        begin
            have_best_next      = 1'b1;
            best_next.width     = cand_reg.mode_width;
            best_next.height    = cand_reg.mode_height;
            best_next.rate      = cand_reg.mode_rate;
            best_next.preferred = cand_reg.preferred;
            best_next.width_mm  = cand_reg.panel_width_mm;
            best_next.height_mm = cand_reg.panel_height_mm;
            best_next.connector = cand_reg.connector_ident;
            best_next.encoder   = cand_reg.encoder_ident;
        end
        else if (load_out)
        begin
            have_best_next = 1'b0;
            best_next      = '0;
        end
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next                 = 1'b1;
            out_data_next.found            = have_best_reg;
            out_data_next.chosen_width     = best_reg.width;
            out_data_next.chosen_height    = best_reg.height;
            out_data_next.chosen_rate      = best_reg.rate;
            out_data_next.chosen_connector = best_reg.connector;
            out_data_next.chosen_encoder   = best_reg.encoder;
            out_data_next.chosen_width_mm  = best_reg.width_mm;
            out_data_next.chosen_height_mm = best_reg.height_mm;
        end
        else if (choice_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign choice_out.valid = out_valid_reg;
    assign choice_out.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmbp_pkg::S_IDLE;
            have_best_reg <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_best_reg <= have_best_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg       <= cand_next;
        best_score_reg <= best_score_next;
        out_data_reg   <= out_data_next;
    end

`ifndef SYNTHESIS
    a_empty_best_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !have_best_reg |-> (best_reg == '0))
        else $error("best mode holds data with no mode taken");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || choice_out.ready))
        else $error("pending choice overwritten");

    a_cleared_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (!have_best_reg && out_valid_reg))
        else $error("state not cleared after the choice was loaded");

    a_ratio_done_when_asked: assert property (@(posedge clk) disable iff (!rst_n)
        ratio_done |-> (state_reg == dmbp_pkg::S_BEST || state_reg == dmbp_pkg::S_NEW))
        else $error("ratio unit finished outside an aspect pass");
`endif

endmodule

### tb/sv/display_mode_best_picker_test.sv
`timescale 1ns / 1ps

module display_mode_best_picker_test;
    import dmbp_pkg::*;

    localparam int          CYCLE_LIMIT        = 1000000;
    localparam int          SETTLE_CYCLES      = 2 * (RATIO_FRAC_BITS + 13) + 3 + 16;
    localparam int          PHASE_ITEMS        = 240;
    localparam int          IDLE_PERCENT       = 27;
    localparam int          OUT_OF_RANGE_INDEX = 7;
    localparam logic [63:0] SCORE_MAX          = (64'd1 << (8 + RATIO_FRAC_BITS)) - 64'd1;

    localparam int COMMON_WIDTHS [10]  = '{640, 800, 1024, 1280, 1366, 1600, 1680, 1920,
                                           2560, 3840};
    localparam int COMMON_HEIGHTS [11] = '{480, 600, 720, 768, 900, 1024, 1050, 1080, 1200,
                                           1440, 2160};
    localparam int PANEL_MM_W [6]      = '{344, 310, 520, 376, 597, 1210};
    localparam int PANEL_MM_H [6]      = '{194, 174, 320, 301, 336, 680};

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    dmbp_mode_if   mode_if();
    dmbp_choice_if choice_if();

    display_mode_best_picker u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_in    (mode_if),
        .choice_out (choice_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mode_t   pending_modes[$];
    choice_t expected_choices[$];
    int      queued_count;
    int      accepted_count;
    int      mismatch_count;
    int      cycle_count;
    bit      mode_fired;
    bit      steady_flow;

    // predictor state
    cfg_t    picker_cfg;
    best_t   held_best;
    bit      holding_best;
    mode_t   prev_mode;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // max(r, 1/r) in Q8.F, saturating
    function automatic logic [63:0] aspect_score(input logic [RES_W-1:0] w,
                                                 input logic [RES_W-1:0] h,
                                                 input logic [MM_W-1:0]  mmw,
                                                 input logic [MM_W-1:0]  mmh);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] q;
        num = 64'(w) * 64'(mmh);
        den = 64'(h) * 64'(mmw);
        hi  = (num < den) ? den : num;
        lo  = (num < den) ? num : den;
        if (lo == 0)
            return SCORE_MAX;
        q = (hi << RATIO_FRAC_BITS) / lo;
        return (q > SCORE_MAX) ? SCORE_MAX : q;
    endfunction

    function automatic bit candidate_wins(input mode_t m);
        bit          a;
        bit          b;
        logic [63:0] margin;
        logic [63:0] best_score;
        logic [63:0] cand_score;
        if (!holding_best)
            return 1'b1;

        a = (held_best.rate == picker_cfg.wanted_rate);
        b = (m.mode_rate == picker_cfg.wanted_rate);
        if (a != b)
            return b;

        a = (held_best.width < picker_cfg.wanted_width) ||
            (held_best.height < picker_cfg.wanted_height);
        b = (m.mode_width < picker_cfg.wanted_width) ||
            (m.mode_height < picker_cfg.wanted_height);
        if (a != b)
            return a;

        a = (held_best.width <= picker_cfg.width_cap);
        b = (m.mode_width <= picker_cfg.width_cap);
        if (a != b)
            return b;

        a = held_best.preferred;
        b = m.preferred;
        if (a != b)
            return b;

        if ((held_best.width != m.mode_width || held_best.height != m.mode_height) &&
            held_best.width_mm != 0 && held_best.height_mm != 0 &&
            m.panel_width_mm != 0 && m.panel_height_mm != 0)
        begin
            margin     = (64'(picker_cfg.aspect_margin) << RATIO_FRAC_BITS) >> 16;
            best_score = aspect_score(held_best.width, held_best.height,
                                      held_best.width_mm, held_best.height_mm);
            cand_score = aspect_score(m.mode_width, m.mode_height,
                                      m.panel_width_mm, m.panel_height_mm);
            if (best_score > cand_score + margin)
                return 1'b1;
            if (cand_score > best_score + margin)
                return 1'b0;
        end

        if (m.mode_width != held_best.width)
            return m.mode_width > held_best.width;
        return m.mode_height > held_best.height;
    endfunction

    task automatic take_candidate(input mode_t m);
        choice_t c;
        if (m.connected && candidate_wins(m))
        begin
            holding_best        = 1'b1;
            held_best.width     = m.mode_width;
            held_best.height    = m.mode_height;
            held_best.rate      = m.mode_rate;
            held_best.preferred = m.preferred;
            held_best.width_mm  = m.panel_width_mm;
            held_best.height_mm = m.panel_height_mm;
            held_best.connector = m.connector_ident;
            held_best.encoder   = m.encoder_ident;
        end
        if (m.last_mode)
        begin
            c = '0;
            if (holding_best)
            begin
                c.found            = 1'b1;
                c.chosen_width     = held_best.width;
                c.chosen_height    = held_best.height;
                c.chosen_rate      = held_best.rate;
                c.chosen_connector = held_best.connector;
                c.chosen_encoder   = held_best.encoder;
                c.chosen_width_mm  = held_best.width_mm;
                c.chosen_height_mm = held_best.height_mm;
            end
            expected_choices.push_back(c);
            holding_best = 1'b0;
            held_best    = '0;
        end
    endtask

    // candidate side: new item picked at the falling edge once the last one transferred
    always @(posedge clk)
    begin
        mode_fired <= mode_if.valid && mode_if.ready;
        if (rst_n && mode_if.valid && mode_if.ready)
        begin
            take_candidate(mode_if.data);
            accepted_count <= accepted_count + 1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            mode_if.valid <= 1'b0;
        else if (!mode_if.valid || mode_fired)
        begin
            if (pending_modes.size() > 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PERCENT))
            begin
                mode_if.valid <= 1'b1;
                mode_if.data  <= pending_modes.pop_front();
            end
            else
                mode_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        choice_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        choice_t exp_c;
        choice_t act_c;
        if (rst_n && choice_if.valid && choice_if.ready)
        begin
            act_c = choice_if.data;
            if (expected_choices.size() == 0)
            begin
                $display("%0t unexpected choice transfer: expected none actual %h",
                         $time, act_c);
                mismatch_count++;
            end
            else
            begin
                exp_c = expected_choices.pop_front();
                check_field("found", exp_c.found, act_c.found);
                check_field("chosen_width", exp_c.chosen_width, act_c.chosen_width);
                check_field("chosen_height", exp_c.chosen_height, act_c.chosen_height);
                check_field("chosen_rate", exp_c.chosen_rate, act_c.chosen_rate);
                check_field("chosen_connector", exp_c.chosen_connector,
                            act_c.chosen_connector);
                check_field("chosen_encoder", exp_c.chosen_encoder, act_c.chosen_encoder);
                check_field("chosen_width_mm", exp_c.chosen_width_mm, act_c.chosen_width_mm);
                check_field("chosen_height_mm", exp_c.chosen_height_mm,
                            act_c.chosen_height_mm);
            end
        end
    end

    task automatic write_register(input int idx, input logic [31:0] value);
        logic [31:0] data;
        // junk above the widest field must be dropped by the block
        data = {16'($urandom_range(0, 65535)), value[15:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * idx);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_WANTED_WIDTH:  picker_cfg.wanted_width  = data[RES_W-1:0];
            REG_WANTED_HEIGHT: picker_cfg.wanted_height = data[RES_W-1:0];
            REG_WANTED_RATE:   picker_cfg.wanted_rate   = data[RATE_W-1:0];
            REG_WIDTH_CAP:     picker_cfg.width_cap     = data[RES_W-1:0];
            REG_ASPECT_MARGIN: picker_cfg.aspect_margin = data[MARGIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input int w, input int h, input int rate, input int cap,
                                  input int margin);
        write_register(REG_WANTED_WIDTH, w);
        write_register(REG_WANTED_HEIGHT, h);
        write_register(REG_WANTED_RATE, rate);
        write_register(REG_WIDTH_CAP, cap);
        write_register(REG_ASPECT_MARGIN, margin);
    endtask

    // wait for every candidate and choice, then let the block go quiet
    task automatic drain();
        while (accepted_count != queued_count || expected_choices.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_mode(input bit conn, input int w, input int h, input int rate,
                              input bit pref, input int mmw, input int mmh, input bit last);
        mode_t m;
        m.connected       = conn;
        m.mode_width      = RES_W'(w);
        m.mode_height     = RES_W'(h);
        m.mode_rate       = RATE_W'(rate);
        m.preferred       = pref;
        m.panel_width_mm  = MM_W'(mmw);
        m.panel_height_mm = MM_W'(mmh);
        m.connector_ident = $urandom();
        m.encoder_ident   = $urandom();
        m.last_mode       = last;
        pending_modes.push_back(m);
        queued_count++;
    endtask

    function automatic logic [RES_W-1:0] pick_resolution(input logic [RES_W-1:0] wanted,
                                                         input logic [RES_W-1:0] cap,
                                                         input bit is_width);
        logic [RES_W-1:0] r;
        case ($urandom_range(9))
            0: r = wanted;
            1: r = wanted - 1'b1;
            2: r = cap;
            3: r = cap + 1'b1;
            4: r = RES_W'($urandom_range(8191));
            5: r = $urandom_range(1) ? 13'd0 : 13'd8191;
            default: r = is_width ? RES_W'(COMMON_WIDTHS[$urandom_range(9)])
                                  : RES_W'(COMMON_HEIGHTS[$urandom_range(10)]);
        endcase
        return r;
    endfunction

    function automatic mode_t random_mode(input bit may_connect, input bit last);
        mode_t m;
        int    k;
        m.connected = may_connect && ($urandom_range(99) < 85);
        if ($urandom_range(4) == 0)
        begin
            // same resolution as the one before, which skips the aspect test when that one is the held best
            m.mode_width  = prev_mode.mode_width;
            m.mode_height = prev_mode.mode_height;
        end
        else
        begin
            m.mode_width  = pick_resolution(picker_cfg.wanted_width, picker_cfg.width_cap, 1'b1);
            m.mode_height = pick_resolution(picker_cfg.wanted_height,
                                            picker_cfg.wanted_height, 1'b0);
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4: m.mode_rate = picker_cfg.wanted_rate;
            5:             m.mode_rate = picker_cfg.wanted_rate + 1'b1;
            6:             m.mode_rate = prev_mode.mode_rate;
            default:       m.mode_rate = RATE_W'($urandom_range(1023));
        endcase
        m.preferred = 1'($urandom_range(1));
        k = $urandom_range(5);
        case ($urandom_range(9))
            0:
            begin
                m.panel_width_mm  = MM_W'($urandom_range(4095));
                m.panel_height_mm = MM_W'($urandom_range(4095));
            end
            1:
            begin
                m.panel_width_mm  = $urandom_range(1) ? 12'd0 : MM_W'(PANEL_MM_W[k]);
                m.panel_height_mm = (m.panel_width_mm == 0) ? MM_W'(PANEL_MM_H[k]) : 12'd0;
            end
            2:
            begin
                m.panel_width_mm  = 12'd4095;
                m.panel_height_mm = $urandom_range(1) ? 12'd4095 : 12'd1;
            end
            default:
            begin
                m.panel_width_mm  = MM_W'(PANEL_MM_W[k]);
                m.panel_height_mm = MM_W'(PANEL_MM_H[k]);
            end
        endcase
        m.connector_ident = $urandom();
        m.encoder_ident   = $urandom();
        m.last_mode       = last;
        prev_mode         = m;
        return m;
    endfunction

    function automatic int queue_random_list();
        int n;
        bit noise;
        n     = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        noise = ($urandom_range(19) == 0);
        for (int i = 0; i < n; i++)
        begin
            pending_modes.push_back(random_mode(!noise, i == n - 1));
            queued_count++;
        end
        return n;
    endfunction

    task automatic run_random_phase();
        int count;
        count = 0;
        while (count < PHASE_ITEMS / 2)
            count += queue_random_list();
        // sender holds off until every choice is back
        drain();
        while (count < PHASE_ITEMS)
            count += queue_random_list();
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mode_if.valid   = 1'b0;
        mode_if.data    = '0;
        choice_if.ready = 1'b0;
        queued_count    = 0;
        accepted_count  = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        mode_fired      = 1'b0;
        steady_flow     = 1'b0;
        holding_best    = 1'b0;
        held_best       = '0;
        prev_mode       = '0;
        picker_cfg      = {WANTED_WIDTH_RST, WANTED_HEIGHT_RST, WANTED_RATE_RST,
                           WIDTH_CAP_RST, ASPECT_MARGIN_RST};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lists at reset settings
        queue_mode(0, 1920, 1080, 60, 1, 520, 320, 1);      // nothing connected
        queue_mode(1, 1920, 1080, 60, 0, 0, 0, 0);
        queue_mode(1, 1280, 720, 60, 0, 0, 0, 0);
        queue_mode(1, 3840, 2160, 60, 1, 0, 0, 0);          // over the width cap
        queue_mode(0, 2560, 1440, 60, 1, 600, 340, 1);      // disconnected last still reports
        queue_mode(1, 1280, 720, 59, 1, 0, 0, 0);
        queue_mode(1, 1024, 600, 60, 0, 0, 0, 1);           // rate match wins
        queue_mode(1, 640, 480, 60, 1, 0, 0, 0);
        queue_mode(1, 800, 600, 60, 0, 0, 0, 1);            // not small wins
        queue_mode(1, 1920, 1080, 60, 0, 0, 0, 0);
        queue_mode(1, 1680, 1050, 60, 1, 0, 0, 1);          // preferred wins
        queue_mode(1, 1280, 1024, 60, 0, 520, 320, 0);
        queue_mode(1, 1680, 1050, 60, 0, 520, 320, 0);      // better aspect wins
        queue_mode(1, 1920, 1080, 60, 0, 520, 320, 0);      // within margin, width decides
        queue_mode(1, 1920, 1440, 60, 0, 520, 320, 0);      // worse aspect loses
        queue_mode(1, 1600, 1200, 60, 0, 520, 320, 1);
        queue_mode(1, 1920, 1080, 60, 0, 0, 320, 0);        // zero mm skips aspect
        queue_mode(1, 1280, 1024, 60, 0, 520, 320, 1);
        queue_mode(1, 1000, 0, 60, 0, 500, 300, 0);         // zero height saturates
        queue_mode(1, 900, 300, 60, 0, 500, 300, 1);
        queue_mode(1, 8191, 1, 60, 0, 1, 4095, 0);          // quotient overflow
        queue_mode(1, 8000, 2, 60, 0, 1, 4095, 1);
        queue_mode(1, 0, 0, 0, 0, 0, 0, 0);
        queue_mode(1, 8191, 8191, 1023, 1, 4095, 4095, 1);
        queue_mode(1, 1920, 1080, 60, 0, 520, 320, 0);
        queue_mode(1, 1920, 1080, 60, 0, 520, 320, 1);      // full tie keeps the first
        drain();

        run_random_phase();

        apply_settings(0, 0, 0, 0, 0);
        run_random_phase();

        apply_settings(8191, 8191, 1023, 8191, 65535);
        write_register(OUT_OF_RANGE_INDEX, $urandom());
        run_random_phase();

        steady_flow = 1'b1;
        apply_settings(1280, 720, 75, 2560, 3277);
        run_random_phase();
        steady_flow = 1'b0;

        for (int p = 0; p < 3; p++)
        begin
            apply_settings($urandom_range(0, 4000), $urandom_range(0, 2400),
                           $urandom_range(1) ? 60 : $urandom_range(1023),
                           $urandom_range(8191), $urandom_range(65535));
            run_random_phase();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
